// ----- hw/rtl/mtts_pkg.sv -----
// Shared types and constants for the mission time tick scheduler.
package mtts_pkg;

   localparam int TIME_WIDTH   = 64;
   localparam int PERIOD_WIDTH = 32;
   localparam int DELTA_WIDTH  = 32;

   localparam logic [PERIOD_WIDTH-1:0] NOTIFY_PERIOD_RESET = 32'd5000;
   localparam logic [PERIOD_WIDTH-1:0] SAVE_PERIOD_RESET   = 32'(15 * 60 * 1000);

   typedef enum logic {
      REQ_TICK = 1'b0,
      REQ_SET  = 1'b1
   } req_kind_type;

   typedef enum logic {
      CSR_NOTIFY_PERIOD = 1'b0,
      CSR_SAVE_PERIOD   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                   advance;
      logic                   is_set;
      logic [DELTA_WIDTH-1:0] delta;
   } mtts_step_type;

endpackage

// ----- hw/rtl/mission_time_tick_scheduler.sv -----
// Top level of the mission time tick scheduler.
// One transaction in gives one transaction out. A tick transaction adds
// req_delta_ms to the 64-bit mission time and to the notify and save
// elapsed counters; a set transaction loads req_new_time_ms and makes both
// rsp_notify_now and rsp_save_now fire. A counter that strictly exceeds its
// period raises its flag and restarts from zero. The block takes one
// transaction per clock while rsp_stall is low: an input register feeds
// one 64-bit add and two 33-bit compares, and the result lands in an
// output register, which drives rsp_valid. The input register keeps
// accepting while a result waits on rsp_stall; req_stall rises only when
// both registers are full and the output is stalled. Period writes
// through the csr port take effect from the next transaction and leave
// the counters untouched.
module mission_time_tick_scheduler
   import mtts_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_type,
   input  logic [DELTA_WIDTH-1:0]  req_delta_ms,
   input  logic [TIME_WIDTH-1:0]   req_new_time_ms,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [TIME_WIDTH-1:0]   rsp_mission_time_ms,
   output logic                    rsp_notify_now,
   output logic                    rsp_save_now,
   // configuration
   input  logic                    csr_write_enable,
   input  logic                    csr_index,
   input  logic [PERIOD_WIDTH-1:0] csr_write_data
);

   // Configuration registers.
   logic [PERIOD_WIDTH-1:0] notify_period_ff;
   logic [PERIOD_WIDTH-1:0] save_period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         notify_period_ff <= NOTIFY_PERIOD_RESET;
         save_period_ff   <= SAVE_PERIOD_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_NOTIFY_PERIOD: notify_period_ff <= csr_write_data;
            CSR_SAVE_PERIOD:   save_period_ff   <= csr_write_data;
         endcase
      end
   end

   // Input register stage.
   logic                   in_valid_ff;
   req_kind_type           in_kind_ff;
   logic [DELTA_WIDTH-1:0] in_delta_ff;
   logic [TIME_WIDTH-1:0]  in_time_ff;

   logic rsp_valid_ff;
   logic out_free;
   logic advance;
   logic req_take;

   // The output register can load when empty or being drained this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   // Payload holds unless a new transaction comes in.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff  <= req_kind_type'(req_type);
         in_delta_ff <= req_delta_ms;
         in_time_ff  <= req_new_time_ms;
      end
   end

   // Mission time and the two elapsed counters advance with the stage.
   logic [TIME_WIDTH-1:0] time_ff;
   logic [TIME_WIDTH-1:0] time_in;
   mtts_step_type         step;
   logic                  notify_fire;
   logic                  save_fire;

   always_comb begin
      step.advance = advance;
      step.is_set  = (in_kind_ff == REQ_SET);
      step.delta   = in_delta_ff;
   end

   // Wraps modulo 2^64.
   assign time_in = step.is_set ? in_time_ff
                                : time_ff + {{(TIME_WIDTH-DELTA_WIDTH){1'b0}}, in_delta_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
      end else if (advance) begin
         time_ff <= time_in;
      end
   end

   mtts_elapsed u_notify (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .period (notify_period_ff),
      .fire   (notify_fire)
   );

   mtts_elapsed u_save (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .period (save_period_ff),
      .fire   (save_fire)
   );

   // Output register.
   logic [TIME_WIDTH-1:0] rsp_time_ff;
   logic                  rsp_notify_ff;
   logic                  rsp_save_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_time_ff   <= time_in;
         rsp_notify_ff <= notify_fire;
         rsp_save_ff   <= save_fire;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mission_time_ms = rsp_time_ff;
   assign rsp_notify_now      = rsp_notify_ff;
   assign rsp_save_now        = rsp_save_ff;

   // A set transaction must raise both flags in its result.
   assert property (@(posedge clock) disable iff (reset)
      (advance && step.is_set) |=> (rsp_valid_ff && rsp_notify_ff && rsp_save_ff))
      else $error("set transaction did not fire both flags");

   // A result leaving the input stage must show up at the output.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_valid_ff && rsp_time_ff == $past(time_in)))
      else $error("advanced transaction lost at output");

   // Stall the request side only when both stages are occupied.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled with free stage");

   // Mission time only moves when a transaction advances.
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(time_ff))
      else $error("mission time changed without a transaction");

endmodule

// ----- hw/rtl/mtts_elapsed.sv -----
// Elapsed-time counter with period check and clear on fire.
module mtts_elapsed
   import mtts_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  mtts_step_type           step,
   input  logic [PERIOD_WIDTH-1:0] period,
   output logic                    fire
);

   // After any check the count never exceeds a period, so 32 bits hold it.
   logic [PERIOD_WIDTH-1:0] count_ff;
   logic [PERIOD_WIDTH-1:0] count_in;
   logic [PERIOD_WIDTH:0]   sum;

   assign sum = {1'b0, count_ff} + {1'b0, step.delta};

   // A set fires unconditionally, and the count then restarts from zero.
   assign fire = step.is_set || (sum > {1'b0, period});

   always_comb begin
      count_in = count_ff;
      if (step.advance) begin
         count_in = fire ? '0 : sum[PERIOD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the mission time tick scheduler: random idling, period sweeps.
module tb
   import mtts_pkg::*;
();

   // Cycles with no transaction on either channel before the run is declared hung.
   // The longest legal quiet stretch is a few stall bursts plus a period update.
   localparam int STUCK_LIMIT     = 1000;
   localparam int SETTLE_CYCLES   = 4;   // margin once the queues are empty
   localparam int DRAIN_CYCLES    = 8;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 241;

   typedef struct packed {
      req_kind_type           kind;
      logic [DELTA_WIDTH-1:0] delta_ms;
      logic [TIME_WIDTH-1:0]  load_ms;
   } time_cmd_type;

   typedef struct packed {
      logic [TIME_WIDTH-1:0] mission_ms;
      logic                  notify;
      logic                  save;
   } time_report_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_type = 1'b0;
   logic [DELTA_WIDTH-1:0]  req_delta_ms = '0;
   logic [TIME_WIDTH-1:0]   req_new_time_ms = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [TIME_WIDTH-1:0]   rsp_mission_time_ms;
   logic                    rsp_notify_now;
   logic                    rsp_save_now;
   logic                    csr_write_enable = 1'b0;
   logic                    csr_index = 1'b0;
   logic [PERIOD_WIDTH-1:0] csr_write_data = '0;

   mission_time_tick_scheduler dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_type            (req_type),
      .req_delta_ms        (req_delta_ms),
      .req_new_time_ms     (req_new_time_ms),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_mission_time_ms (rsp_mission_time_ms),
      .rsp_notify_now      (rsp_notify_now),
      .rsp_save_now        (rsp_save_now),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   // Commands waiting to go out, and the reports they must produce, oldest first.
   time_cmd_type    cmd_queue[$];
   time_report_type report_queue[$];
   time_cmd_type    cmd_on_bus;

   // Shadow of the period registers and of the block's time keeping.
   logic [PERIOD_WIDTH-1:0] notify_cfg;
   logic [PERIOD_WIDTH-1:0] save_cfg;
   logic [TIME_WIDTH-1:0]   mission_ms_model;
   logic [TIME_WIDTH-1:0]   notify_elapsed_model;
   logic [TIME_WIDTH-1:0]   save_elapsed_model;

   bit gaps_on;
   bit stalls_on;
   int send_gap;
   int stall_left;
   int cmds_sent;
   int reports_seen;
   int mismatches;
   int notify_seen;
   int save_seen;
   int cfg_writes;

   initial begin
      forever #4 clock = ~clock;
   end

   // Apply one command to the shadow state and return the report it must yield.
   function automatic time_report_type advance_mission_clock(time_cmd_type cmd);
      time_report_type rep;
      if (cmd.kind == REQ_TICK) begin
         // all three sums wrap modulo 2^64
         mission_ms_model     = mission_ms_model + cmd.delta_ms;
         notify_elapsed_model = notify_elapsed_model + cmd.delta_ms;
         save_elapsed_model   = save_elapsed_model + cmd.delta_ms;
      end else begin
         // preset one past the period, in 64 bits, so both events fire now
         mission_ms_model     = cmd.load_ms;
         notify_elapsed_model = {32'd0, notify_cfg} + 64'd1;
         save_elapsed_model   = {32'd0, save_cfg} + 64'd1;
      end
      rep.mission_ms = mission_ms_model;
      rep.save       = save_elapsed_model > {32'd0, save_cfg};
      rep.notify     = notify_elapsed_model > {32'd0, notify_cfg};
      if (rep.save) save_elapsed_model = '0;
      if (rep.notify) notify_elapsed_model = '0;
      return rep;
   endfunction

   function automatic void queue_time_cmd(req_kind_type kind, logic [DELTA_WIDTH-1:0] delta,
                                          logic [TIME_WIDTH-1:0] load);
      time_cmd_type cmd;
      cmd.kind     = kind;
      cmd.delta_ms = delta;
      cmd.load_ms  = load;
      cmd_queue.push_back(cmd);
   endfunction

   // Period values weighted toward the edges: zero, one, all ones, the reset value.
   function automatic logic [PERIOD_WIDTH-1:0] pick_period(logic [PERIOD_WIDTH-1:0] dflt);
      logic [PERIOD_WIDTH-1:0] p;
      case ($urandom_range(0, 6))
         0: p = '0;
         1: p = 32'd1;
         2: p = '1;
         3: p = $urandom_range(0, 100);
         4: p = $urandom_range(1000, 30000);
         5: p = dflt;
         default: p = $urandom;
      endcase
      return p;
   endfunction

   // Write one period register; the block is idle, so update the shadow at once.
   task automatic write_period(csr_index_type idx, logic [PERIOD_WIDTH-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_NOTIFY_PERIOD) notify_cfg = value;
      else save_cfg = value;
      cfg_writes++;
   endtask

   // Hold the sender until every command is out and every report is back.
   task automatic drain;
      while (cmd_queue.size() != 0 || req_valid || report_queue.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Driver: present commands from the queue, with random gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // predict on acceptance, so the expectation order follows the bus
         if (req_valid && !req_stall) begin
            report_queue.push_back(advance_mission_clock(cmd_on_bus));
            cmds_sent++;
         end
         // a stalled transaction holds its payload untouched
         if (!req_valid || !req_stall) begin
            if (send_gap == 0 && gaps_on && cmd_queue.size() != 0 &&
                $urandom_range(0, 7) == 0)
               send_gap = $urandom_range(1, 12);
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
               cmd_on_bus = cmd_queue.pop_front();
               req_valid       <= 1'b1;
               req_type        <= cmd_on_bus.kind;
               req_delta_ms    <= cmd_on_bus.delta_ms;
               req_new_time_ms <= cmd_on_bus.load_ms;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each report against the oldest expectation, and stall in bursts.
   always @(posedge clock) begin : check_reports
      time_report_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            reports_seen++;
            notify_seen += rsp_notify_now;
            save_seen   += rsp_save_now;
            if (report_queue.size() == 0) begin
               if (mismatches < 10)
                  $display("ERROR: unexpected report time=%h notify=%b save=%b",
                           rsp_mission_time_ms, rsp_notify_now, rsp_save_now);
               mismatches++;
            end else begin
               want = report_queue.pop_front();
               if (rsp_mission_time_ms !== want.mission_ms ||
                   rsp_notify_now !== want.notify || rsp_save_now !== want.save) begin
                  if (mismatches < 10)
                     $display("ERROR: report %0d exp time=%h notify=%b save=%b, got %h %b %b",
                              reports_seen, want.mission_ms, want.notify, want.save,
                              rsp_mission_time_ms, rsp_notify_now, rsp_save_now);
                  mismatches++;
               end
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (stalls_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 11);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: give up when neither channel moves for too long.
   initial begin : watchdog
      int stuck;
      int last_in;
      int last_out;
      stuck    = 0;
      last_in  = 0;
      last_out = 0;
      while (stuck < STUCK_LIMIT) begin
         @(negedge clock);
         if (cmds_sent != last_in || reports_seen != last_out) begin
            stuck    = 0;
            last_in  = cmds_sent;
            last_out = reports_seen;
         end else begin
            stuck++;
         end
      end
      $display("tb failed");
      $finish;
   end

   initial begin : run
      int ph;
      int n;
      logic [DELTA_WIDTH-1:0] delta;
      logic [TIME_WIDTH-1:0]  load;

      notify_cfg           = NOTIFY_PERIOD_RESET;
      save_cfg             = SAVE_PERIOD_RESET;
      mission_ms_model     = '0;
      notify_elapsed_model = '0;
      save_elapsed_model   = '0;
      gaps_on   = 1'b1;
      stalls_on = 1'b1;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset periods: approach the notify boundary from below, then cross it.
      @(negedge clock);
      queue_time_cmd(REQ_TICK, 32'd0, 64'd0);
      queue_time_cmd(REQ_TICK, 32'd4999, '1);          // unused load ignored
      queue_time_cmd(REQ_TICK, 32'd1, 64'd0);          // equal to period: quiet
      queue_time_cmd(REQ_TICK, 32'd1, 64'd0);          // one past: notify
      queue_time_cmd(REQ_TICK, '1, 64'd0);
      queue_time_cmd(REQ_SET, '1, 64'hFFFF_FFFF_FFFF_FFF0);  // unused delta ignored
      queue_time_cmd(REQ_TICK, 32'h20, 64'd0);         // mission time wraps
      queue_time_cmd(REQ_SET, 32'd0, 64'd0);
      queue_time_cmd(REQ_TICK, 32'd900000, 64'd0);     // save exactly at period
      queue_time_cmd(REQ_TICK, 32'd1, 64'd0);
      queue_time_cmd(REQ_TICK, 32'd100, 64'd0);        // leave counters nonzero
      drain();

      // Zero periods: any nonzero counter fires.
      write_period(CSR_NOTIFY_PERIOD, '0);
      write_period(CSR_SAVE_PERIOD, '0);
      @(negedge clock);
      queue_time_cmd(REQ_TICK, 32'd0, 64'd0);
      queue_time_cmd(REQ_TICK, 32'd1, 64'd0);
      queue_time_cmd(REQ_SET, 32'd0, 64'h8000_0000_0000_0000);
      queue_time_cmd(REQ_TICK, 32'd0, 64'd0);
      drain();

      // All-ones periods: the preset and the counters need the 33rd bit.
      write_period(CSR_NOTIFY_PERIOD, '1);
      write_period(CSR_SAVE_PERIOD, '1);
      @(negedge clock);
      queue_time_cmd(REQ_SET, 32'd0, 64'd0);
      queue_time_cmd(REQ_TICK, '1, 64'd0);
      queue_time_cmd(REQ_TICK, 32'd0, 64'd0);
      queue_time_cmd(REQ_TICK, 32'd1, 64'd0);
      queue_time_cmd(REQ_TICK, '1, 64'd0);
      queue_time_cmd(REQ_TICK, '1, 64'd0);
      drain();

      // Random phases, each under fresh periods; the last one runs without idling.
      for (ph = 0; ph < RANDOM_PHASES; ph++) begin
         write_period(CSR_NOTIFY_PERIOD, pick_period(NOTIFY_PERIOD_RESET));
         write_period(CSR_SAVE_PERIOD, pick_period(SAVE_PERIOD_RESET));
         gaps_on   = (ph != RANDOM_PHASES - 1) && (ph % 3 != 2);
         stalls_on = (ph != RANDOM_PHASES - 1) && (ph % 3 != 1);
         @(negedge clock);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 9) == 0) begin
               if ($urandom_range(0, 3) == 0) load = ~64'd0 - $urandom_range(0, 300);
               else load = {$urandom, $urandom};
               queue_time_cmd(REQ_SET, $urandom, load);
            end else begin
               case ($urandom_range(0, 9))
                  0: delta = '0;
                  1: delta = '1;
                  2, 3, 4: delta = $urandom_range(0, 300);
                  5, 6: delta = $urandom_range(0, 20000);
                  7: delta = $urandom;
                  8: delta = notify_cfg + $urandom_range(0, 2) - 1;
                  default: delta = save_cfg + $urandom_range(0, 2) - 1;
               endcase
               queue_time_cmd(REQ_TICK, delta, {$urandom, $urandom});
            end
         end
         drain();
      end

      // Catch any stray report after the last expected one.
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run: %0d transactions in, %0d out, %0d notify and %0d save events.",
               cmds_sent, reports_seen, notify_seen, save_seen);
      $display("Periods rewritten %0d times, zero and all-ones included; %0d mismatches.",
               cfg_writes, mismatches);
      if (mismatches == 0 && report_queue.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/mtts_pkg.sv
hw/rtl/mtts_elapsed.sv
hw/rtl/mission_time_tick_scheduler.sv
test/tb.sv
